[rtl/anchored_union_find_engine_unit_assert.svh]
// Assertion macros shared by the engine's modules.
// Both forms are clocked and are switched off while reset is asserted.
`ifndef ANCHORED_UNION_FIND_ENGINE_UNIT_ASSERT_SVH
`define ANCHORED_UNION_FIND_ENGINE_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// A property that must hold at every clock edge outside reset.
`define AUFE_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("aufe: assertion failed");

// A condition that must be followed by another one on the next edge.
`define AUFE_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("aufe: assertion failed");

`else

`define AUFE_ASSERT(label, clk, rst_n, prop)
`define AUFE_ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

[rtl/aufe_pkg.sv]
package aufe_pkg;

    // Table geometry.
    localparam int ELEMENTS = 1024;
    localparam int IDX_W    = $clog2(ELEMENTS);
    localparam int SIZE_W   = IDX_W + 1;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [SIZE_W-1:0] t_size;

    // The fixed anchor set.
    localparam t_idx ANCHOR = '0;

    // Join request payload.
    typedef struct packed {
        logic [9:0] first_element;
        logic [9:0] second_element;
    } t_join;

    // Result payload.
    typedef struct packed {
        logic [9:0]  merged_root;
        logic [10:0] merged_size;
        logic [9:0]  anchor_size;
        logic        did_merge;
    } t_result;

    // Controller states.
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FIND_START,
        S_FIND_WALK,
        S_COMP_START,
        S_COMP_WALK,
        S_SZ_A,
        S_SZ_B,
        S_SZ_Z,
        S_MERGE,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_ready;
        logic load_in;
        logic clr_write;
        logic find_issue;
        logic find_step;
        logic comp_issue;
        logic comp_step;
        logic save_a;
        logic save_b;
        logic sz_a;
        logic sz_b;
        logic sz_z;
        logic merge;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic root_hit;
        logic node_is_root;
        logic out_free;
    } t_sts;

endpackage

[rtl/aufe_channels_if.sv]
// Join request channel.
interface aufe_join_if;
    logic            valid;
    logic            ready;
    aufe_pkg::t_join payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// Result channel.
interface aufe_result_if;
    logic              valid;
    logic              ready;
    aufe_pkg::t_result payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[rtl/aufe_ram.sv]
// Simple dual-port RAM: one write port, one read port, registered read.
module aufe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/aufe_ctrl.sv]
`include "anchored_union_find_engine_unit_assert.svh"

// Sequencer for table clearing, the two root walks, the merge and the result hand-off.
module aufe_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  aufe_pkg::t_sts i_sts,
    output aufe_pkg::t_cmd o_cmd
);

    aufe_pkg::t_state r_state;
    aufe_pkg::t_state n_state;
    logic             r_pass;
    logic             n_pass;
    aufe_pkg::t_cmd   w_cmd;

    // State and pass registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aufe_pkg::S_CLEAR;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_pass  = r_pass;
        w_cmd   = '0;
        unique case (r_state)
            aufe_pkg::S_CLEAR: begin
                w_cmd.clr_write = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = aufe_pkg::S_IDLE;
                end
            end
            aufe_pkg::S_IDLE: begin
                w_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    w_cmd.load_in = 1'b1;
                    n_pass        = 1'b0;
                    n_state       = aufe_pkg::S_FIND_START;
                end
            end
            aufe_pkg::S_FIND_START: begin
                w_cmd.find_issue = 1'b1;
                n_state          = aufe_pkg::S_FIND_WALK;
            end
            aufe_pkg::S_FIND_WALK: begin
                w_cmd.find_step = 1'b1;
                if (i_sts.root_hit) begin
                    n_state = aufe_pkg::S_COMP_START;
                end
            end
            aufe_pkg::S_COMP_START: begin
                if (i_sts.node_is_root) begin
                    // The path is already flat: this walk is finished.
                    if (!r_pass) begin
                        w_cmd.save_a = 1'b1;
                        n_pass       = 1'b1;
                        n_state      = aufe_pkg::S_FIND_START;
                    end else begin
                        w_cmd.save_b = 1'b1;
                        n_state      = aufe_pkg::S_SZ_A;
                    end
                end else begin
                    w_cmd.comp_issue = 1'b1;
                    n_state          = aufe_pkg::S_COMP_WALK;
                end
            end
            aufe_pkg::S_COMP_WALK: begin
                w_cmd.comp_step = 1'b1;
                if (i_sts.root_hit) begin
                    if (!r_pass) begin
                        w_cmd.save_a = 1'b1;
                        n_pass       = 1'b1;
                        n_state      = aufe_pkg::S_FIND_START;
                    end else begin
                        w_cmd.save_b = 1'b1;
                        n_state      = aufe_pkg::S_SZ_A;
                    end
                end
            end
            aufe_pkg::S_SZ_A: begin
                w_cmd.sz_a = 1'b1;
                n_state    = aufe_pkg::S_SZ_B;
            end
            aufe_pkg::S_SZ_B: begin
                w_cmd.sz_b = 1'b1;
                n_state    = aufe_pkg::S_SZ_Z;
            end
            aufe_pkg::S_SZ_Z: begin
                w_cmd.sz_z = 1'b1;
                n_state    = aufe_pkg::S_MERGE;
            end
            aufe_pkg::S_MERGE: begin
                w_cmd.merge = 1'b1;
                n_state     = aufe_pkg::S_DONE;
            end
            aufe_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    w_cmd.load_out = 1'b1;
                    n_state        = aufe_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = aufe_pkg::S_IDLE;
            end
        endcase
    end

    assign o_cmd = w_cmd;

    // The clearing pass runs once after reset and never again.
    `AUFE_ASSERT_NEXT(a_clear_once, i_clk, i_rst_n, r_state != aufe_pkg::S_CLEAR,
        r_state != aufe_pkg::S_CLEAR)
    // An accepted transaction always starts with the first root walk.
    `AUFE_ASSERT_NEXT(a_accept_walk, i_clk, i_rst_n, w_cmd.load_in,
        (r_state == aufe_pkg::S_FIND_START) && !r_pass)

endmodule

[rtl/aufe_dp.sv]
`include "anchored_union_find_engine_unit_assert.svh"

// Parent and size tables, walk registers, merge arithmetic and the output register.
module aufe_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  aufe_pkg::t_cmd    i_cmd,
    input  aufe_pkg::t_join   i_join_data,
    input  logic              i_out_ready,
    output aufe_pkg::t_sts    o_sts,
    output logic              o_out_valid,
    output aufe_pkg::t_result o_out_data
);

    // Walk and merge registers.
    aufe_pkg::t_idx    r_clr_idx, n_clr_idx;
    aufe_pkg::t_idx    r_node, n_node;
    aufe_pkg::t_idx    r_root, n_root;
    aufe_pkg::t_idx    r_b, n_b;
    aufe_pkg::t_idx    r_ra, n_ra;
    aufe_pkg::t_idx    r_rb, n_rb;
    aufe_pkg::t_size   r_size_a, n_size_a;
    aufe_pkg::t_size   r_size_b, n_size_b;
    aufe_pkg::t_result r_res, n_res;
    aufe_pkg::t_result r_out, n_out;
    logic              r_out_valid, n_out_valid;

    // Table ports.
    logic            w_p_we, w_p_re;
    aufe_pkg::t_idx  w_p_waddr, w_p_wdata, w_p_raddr, w_p_rdata;
    logic            w_s_we, w_s_re;
    aufe_pkg::t_idx  w_s_waddr, w_s_raddr;
    aufe_pkg::t_size w_s_wdata, w_s_rdata;

    // Merge arithmetic.
    logic [aufe_pkg::SIZE_W:0] w_sum;
    aufe_pkg::t_size           w_sum_sat;
    aufe_pkg::t_size           w_root_size;
    aufe_pkg::t_size           w_anchor_val;
    aufe_pkg::t_idx            w_root;
    logic                      w_merged;
    logic                      w_root_hit;

    aufe_ram #(
        .WIDTH (aufe_pkg::IDX_W),
        .DEPTH (aufe_pkg::ELEMENTS)
    ) u_parent_ram (
        .i_clk   (i_clk),
        .i_we    (w_p_we),
        .i_waddr (w_p_waddr),
        .i_wdata (w_p_wdata),
        .i_re    (w_p_re),
        .i_raddr (w_p_raddr),
        .o_rdata (w_p_rdata)
    );

    aufe_ram #(
        .WIDTH (aufe_pkg::SIZE_W),
        .DEPTH (aufe_pkg::ELEMENTS)
    ) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (w_s_we),
        .i_waddr (w_s_waddr),
        .i_wdata (w_s_wdata),
        .i_re    (w_s_re),
        .i_raddr (w_s_raddr),
        .o_rdata (w_s_rdata)
    );

    // The parent just read is the walk's current root (or the walk's end).
    assign w_root_hit = (w_p_rdata == r_root);

    // The union decision: the anchor absorbs, otherwise the second root absorbs.
    assign w_merged    = (r_ra != r_rb);
    assign w_root      = (!w_merged || (r_ra == aufe_pkg::ANCHOR)) ? r_ra : r_rb;
    assign w_sum       = {1'b0, r_size_a} + {1'b0, r_size_b};
    assign w_sum_sat   = w_sum[aufe_pkg::SIZE_W] ? '1 : w_sum[aufe_pkg::SIZE_W-1:0];
    assign w_root_size = w_merged ? w_sum_sat : r_size_a;
    // In the merge cycle the size table returns the anchor entry.
    assign w_anchor_val = (w_merged && (w_root == aufe_pkg::ANCHOR)) ? w_sum_sat : w_s_rdata;

    // Command decoding.
    always_comb begin
        n_clr_idx   = r_clr_idx;
        n_node      = r_node;
        n_root      = r_root;
        n_b         = r_b;
        n_ra        = r_ra;
        n_rb        = r_rb;
        n_size_a    = r_size_a;
        n_size_b    = r_size_b;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        w_p_we    = 1'b0;
        w_p_waddr = r_node;
        w_p_wdata = r_root;
        w_p_re    = 1'b0;
        w_p_raddr = r_root;
        w_s_we    = 1'b0;
        w_s_waddr = r_clr_idx;
        w_s_wdata = w_sum_sat;
        w_s_re    = 1'b0;
        w_s_raddr = aufe_pkg::ANCHOR;

        // Clearing pass: every entry its own root, size one, anchor size zero.
        if (i_cmd.clr_write) begin
            w_p_we    = 1'b1;
            w_p_waddr = r_clr_idx;
            w_p_wdata = r_clr_idx;
            w_s_we    = 1'b1;
            w_s_waddr = r_clr_idx;
            w_s_wdata = (r_clr_idx == aufe_pkg::ANCHOR) ? aufe_pkg::t_size'(0)
                                                        : aufe_pkg::t_size'(1);
            n_clr_idx = r_clr_idx + aufe_pkg::t_idx'(1);
        end

        // The field width equals the table index width, so no wrap is needed.
        if (i_cmd.load_in) begin
            n_node = i_join_data.first_element;
            n_root = i_join_data.first_element;
            n_b    = i_join_data.second_element;
        end

        // Root walk: one parent read per cycle.
        if (i_cmd.find_issue) begin
            w_p_re    = 1'b1;
            w_p_raddr = r_root;
        end
        if (i_cmd.find_step && !w_root_hit) begin
            n_root    = w_p_rdata;
            w_p_re    = 1'b1;
            w_p_raddr = w_p_rdata;
        end

        // Compression walk: point each node at the root while reading its old parent.
        if (i_cmd.comp_issue) begin
            w_p_re    = 1'b1;
            w_p_raddr = r_node;
        end
        if (i_cmd.comp_step) begin
            w_p_we    = 1'b1;
            w_p_waddr = r_node;
            w_p_wdata = r_root;
            n_node    = w_p_rdata;
            if (!w_root_hit) begin
                w_p_re    = 1'b1;
                w_p_raddr = w_p_rdata;
            end
        end

        // End of a walk: keep the root; after the first walk, also set up the second walk.
        if (i_cmd.save_a) begin
            n_ra   = r_root;
            n_node = r_b;
            n_root = r_b;
        end
        if (i_cmd.save_b) begin
            n_rb = r_root;
        end

        // Size reads for both roots and the anchor.
        if (i_cmd.sz_a) begin
            w_s_re    = 1'b1;
            w_s_raddr = r_ra;
        end
        if (i_cmd.sz_b) begin
            w_s_re    = 1'b1;
            w_s_raddr = r_rb;
            n_size_a  = w_s_rdata;
        end
        if (i_cmd.sz_z) begin
            w_s_re    = 1'b1;
            w_s_raddr = aufe_pkg::ANCHOR;
            n_size_b  = w_s_rdata;
        end

        // Merge: if the roots differ, hang the absorbed root and grow the surviving size; always fill the result.
        if (i_cmd.merge) begin
            if (w_merged) begin
                w_p_we    = 1'b1;
                w_p_waddr = (r_ra == aufe_pkg::ANCHOR) ? r_rb : r_ra;
                w_p_wdata = w_root;
                w_s_we    = 1'b1;
                w_s_waddr = w_root;
                w_s_wdata = w_sum_sat;
            end
            n_res.merged_root = w_root;
            n_res.merged_size = w_root_size;
            n_res.anchor_size = w_anchor_val[aufe_pkg::IDX_W] ? '1
                                : w_anchor_val[aufe_pkg::IDX_W-1:0];
            n_res.did_merge   = w_merged;
        end

        // Output register.
        if (i_cmd.load_out) begin
            n_out       = r_res;
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_clr_idx   <= n_clr_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_node   <= n_node;
        r_root   <= n_root;
        r_b      <= n_b;
        r_ra     <= n_ra;
        r_rb     <= n_rb;
        r_size_a <= n_size_a;
        r_size_b <= n_size_b;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign o_sts.clr_last     = (r_clr_idx == aufe_pkg::t_idx'(aufe_pkg::ELEMENTS - 1));
    assign o_sts.root_hit     = w_root_hit;
    assign o_sts.node_is_root = (r_node == r_root);
    assign o_sts.out_free     = !r_out_valid || i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_out_data         = r_out;

    // The parent table is never read and written at one address in one cycle.
    `AUFE_ASSERT(a_parent_no_collide, i_clk, i_rst_n,
        !(w_p_we && w_p_re && (w_p_waddr == w_p_raddr)))
    // When the anchor is the result root, both reported sizes agree.
    `AUFE_ASSERT(a_anchor_sizes_agree, i_clk, i_rst_n,
        !i_cmd.load_out || (r_res.merged_root != aufe_pkg::ANCHOR)
        || ({1'b0, r_res.anchor_size} == r_res.merged_size))

endmodule

[rtl/anchored_union_find_engine_unit.sv]
// Anchored disjoint-set engine with set sizes, 1024 entries, entry 0 the anchor.
// i_join carries one join request (two element indices); o_result returns exactly
// one transaction per request: merged root, its size, the anchor set's size and
// a merged flag. Joining an element with itself is a query.
// After reset the block sweeps both tables, one entry per cycle, with
// i_join.ready low; it then accepts requests one at a time.
// From acceptance to the result register, a request walks the parent chains
// from the two elements to their roots: the single read port of the parent
// table is walked once per step to find each root and once more to compress
// the path, and the size table is read three times before the merge. Path
// compression keeps chains short.
// The next request is accepted once the result has moved on from the result
// register to the output register, so a new request can enter even while the
// result still waits; if o_result stays stalled, the following request is held
// in the engine until the output register frees.
module anchored_union_find_engine_unit (
    input logic           i_clk,
    input logic           i_rst_n,
    aufe_join_if.sink     i_join,
    aufe_result_if.source o_result
);

    aufe_pkg::t_cmd w_cmd;
    aufe_pkg::t_sts w_sts;

    aufe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_join.valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    aufe_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_join_data (i_join.payload),
        .i_out_ready (o_result.ready),
        .o_sts       (w_sts),
        .o_out_valid (o_result.valid),
        .o_out_data  (o_result.payload)
    );

    assign i_join.ready = w_cmd.in_ready;

endmodule
